// ===== hw/rtl/pimf_pkg.sv =====
// Shared types and constants for the pixel ID mode finder.
package pimf_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_W         = 32;
    localparam int COUNT_W       = 7;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last_pixel;
    } pimf_in_t;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   winner_key;
        logic [COUNT_W-1:0] winner_count;
        logic               table_overflow;
    } pimf_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } pimf_entry_t;

    // Update request from the scan controller to the best tracker.
    typedef struct packed {
        logic               en;
        logic               ovf;
        logic               clr;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } pimf_upd_t;

endpackage

// ===== hw/rtl/pimf_table_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
module pimf_table_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 39
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/pimf_best.sv =====
// Tracks the most frequent key of the frame and the overflow flag.
module pimf_best (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pimf_pkg::pimf_upd_t              upd,
    output logic [pimf_pkg::KEY_W-1:0]       best_key,
    output logic [pimf_pkg::COUNT_W-1:0]     best_count,
    output logic                             overflow
);

    logic [pimf_pkg::KEY_W-1:0]   key_reg,   key_next;
    logic [pimf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         ovf_reg,   ovf_next;
    logic                         take;

    // Higher count wins; among equal counts the smaller key.
    assign take = upd.en && ((upd.count > count_reg) ||
                             ((upd.count == count_reg) && (upd.key < key_reg)));

    always_comb begin
        key_next   = key_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (upd.clr) begin
            key_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end else begin
            if (take) begin
                key_next   = upd.key;
                count_next = upd.count;
            end
            if (upd.ovf) begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            key_reg   <= key_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign best_key   = key_reg;
    assign best_count = count_reg;
    assign overflow   = ovf_reg;

endmodule

// ===== hw/rtl/pixel_id_mode_finder.sv =====
// Top level of the pixel ID mode finder: table scan controller and result register.
//
// Each accepted pixel forms a 32-bit key from its RGBA bytes; pixels with red, green and
// blue all zero are background and are skipped. Any other pixel is searched against the
// filled entries of a 16-entry key/count table held in a synchronous memory, one entry
// per cycle through its single read port, stopping early on a match. A new key goes into
// the next free entry; a new key arriving on a full table is dropped and flags overflow.
// On a transaction with last_pixel set, one result (found, winner key, winner count,
// overflow) is loaded into the output register once the pixel is handled, and the table
// and tracker are cleared at once; the input stalls until that result register is free
// again. Counts saturate at 127. Valid entries always form a prefix of the table, so a
// fill count replaces per-entry valid bits and no clearing pass is needed after reset.
module pixel_id_mode_finder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pimf_pkg::pimf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pimf_pkg::pimf_out_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                              state_reg,   state_next;
    logic [pimf_pkg::KEY_W-1:0]          key_reg,     key_next;
    logic                                last_reg,    last_next;
    logic [pimf_pkg::FILL_W-1:0]         fill_reg,    fill_next;
    logic [pimf_pkg::FILL_W-1:0]         issue_reg,   issue_next;
    logic                                rd_vld_reg,  rd_vld_next;
    logic [pimf_pkg::IDX_W-1:0]          rd_idx_reg,  rd_idx_next;
    logic                                m_valid_reg, m_valid_next;
    pimf_pkg::pimf_out_t                 m_data_reg,  m_data_next;

    logic                                ram_we;
    logic [pimf_pkg::IDX_W-1:0]          ram_waddr;
    pimf_pkg::pimf_entry_t               wr_entry;
    logic                                ram_re;
    logic [pimf_pkg::IDX_W-1:0]          ram_raddr;
    logic [$bits(pimf_pkg::pimf_entry_t)-1:0] ram_rdata;
    pimf_pkg::pimf_entry_t               rd_entry;

    pimf_pkg::pimf_upd_t                 upd;
    logic [pimf_pkg::KEY_W-1:0]          best_key;
    logic [pimf_pkg::COUNT_W-1:0]        best_count;
    logic                                best_ovf;

    logic                                s_fire;
    logic                                background;
    logic                                hit;
    logic                                more;
    logic                                out_free;

    assign rd_entry   = ram_rdata;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign background = (s_data.red | s_data.green | s_data.blue) == 8'd0;
    assign hit        = rd_vld_reg && (rd_entry.key == key_reg);
    assign more       = issue_reg < fill_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        fill_next    = fill_reg;
        issue_next   = issue_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = rd_idx_reg;
        wr_entry     = '0;
        ram_re       = 1'b0;
        ram_raddr    = issue_reg[pimf_pkg::IDX_W-1:0];
        upd          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    key_next   = {s_data.alpha, s_data.blue, s_data.green, s_data.red};
                    last_next  = s_data.last_pixel;
                    issue_next = '0;
                    if (background) begin
                        state_next = s_data.last_pixel ? ST_EMIT : ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // Bump the matching entry, saturate at the count limit.
                    ram_we         = 1'b1;
                    ram_waddr      = rd_idx_reg;
                    wr_entry.key   = key_reg;
                    wr_entry.count = (rd_entry.count == pimf_pkg::COUNT_LIMIT) ?
                                     rd_entry.count : rd_entry.count + 1'b1;
                    upd.en         = 1'b1;
                    upd.key        = key_reg;
                    upd.count      = wr_entry.count;
                    state_next     = last_reg ? ST_EMIT : ST_IDLE;
                end else if (more) begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[pimf_pkg::IDX_W-1:0];
                    issue_next  = issue_reg + pimf_pkg::FILL_W'(1);
                end else begin
                    // All filled entries checked: insert or drop.
                    if (fill_reg == pimf_pkg::FILL_W'(pimf_pkg::TABLE_ENTRIES)) begin
                        upd.ovf = 1'b1;
                    end else begin
                        ram_we         = 1'b1;
                        ram_waddr      = fill_reg[pimf_pkg::IDX_W-1:0];
                        wr_entry.key   = key_reg;
                        wr_entry.count = pimf_pkg::COUNT_W'(1);
                        upd.en         = 1'b1;
                        upd.key        = key_reg;
                        upd.count      = pimf_pkg::COUNT_W'(1);
                        fill_next      = fill_reg + pimf_pkg::FILL_W'(1);
                    end
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                // Hold until the result register is free, then load it and clear the frame.
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.found           = (best_count != '0);
                    m_data_next.winner_key      = (best_count != '0) ? best_key : '0;
                    m_data_next.winner_count    = best_count;
                    m_data_next.table_overflow  = best_ovf;
                    upd.clr                     = 1'b1;
                    fill_next                   = '0;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg    <= key_next;
        last_reg   <= last_next;
        issue_reg  <= issue_next;
        rd_idx_reg <= rd_idx_next;
        m_data_reg <= m_data_next;
    end

    pimf_table_ram #(
        .DEPTH (pimf_pkg::TABLE_ENTRIES),
        .WIDTH ($bits(pimf_pkg::pimf_entry_t))
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pimf_best u_best (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd        (upd),
        .best_key   (best_key),
        .best_count (best_count),
        .overflow   (best_ovf)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/pimf_checker.sv =====
// Port-level checks for the pixel ID mode finder, bound to the top level.
module pimf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input pimf_pkg::pimf_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input pimf_pkg::pimf_out_t m_data
);

    // Hold a stalled result transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> (m_data.winner_key == '0) && (m_data.winner_count == '0))
        else $error("empty frame reports a winner");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.winner_count != '0)
        else $error("found frame with zero count");

    // A dropped key needs a full table, so something was counted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_overflow |-> m_data.found)
        else $error("overflow without any counted key");

    // Hold off the input while a counted pixel or a frame end is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_data.last_pixel || ((s_data.red | s_data.green | s_data.blue) != 8'd0))
        |=> !s_ready)
        else $error("input accepted during a table scan");

endmodule

bind pixel_id_mode_finder pimf_checker u_pimf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/tb.sv =====
// Testbench for the pixel ID mode finder: frame stimulus, predicted modes and result checks.
`timescale 1ns / 1ps

module tb;
    import pimf_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    pimf_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    pimf_out_t m_data;

    pixel_id_mode_finder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mode tracker mirror: key/count table, current leader, drop flag.
    logic [KEY_W-1:0]   tbl_key  [TABLE_ENTRIES];
    logic [COUNT_W-1:0] tbl_cnt  [TABLE_ENTRIES];
    bit                 tbl_used [TABLE_ENTRIES];
    logic [KEY_W-1:0]   lead_key;
    logic [COUNT_W-1:0] lead_cnt;
    bit                 key_dropped;

    pimf_out_t expected_modes[$];

    bit steady_flow = 1'b0;
    int err_count = 0;
    int pixels_sent = 0;
    int frames_done = 0;
    int overflow_frames = 0;
    int saturated_frames = 0;
    int empty_frames = 0;

    function void clear_tally();
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_used[i] = 1'b0;
        lead_key    = '0;
        lead_cnt    = '0;
        key_dropped = 1'b0;
    endfunction

    function void weigh_leader(input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] cnt);
        if (cnt > lead_cnt || (cnt == lead_cnt && key < lead_key)) begin
            lead_key = key;
            lead_cnt = cnt;
        end
    endfunction

    function void tally_pixel(input pimf_in_t px);
        logic [KEY_W-1:0] key;
        int free_slot;
        bit hit;
        pimf_out_t res;
        key = {px.alpha, px.blue, px.green, px.red};
        if ({px.red, px.green, px.blue} != 24'd0) begin
            hit = 1'b0;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_used[i]) begin
                    if (!hit && tbl_key[i] == key) begin
                        hit = 1'b1;
                        if (tbl_cnt[i] < COUNT_LIMIT) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
                        weigh_leader(key, tbl_cnt[i]);
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (!hit) begin
                if (free_slot < 0) begin
                    key_dropped = 1'b1;
                end else begin
                    tbl_used[free_slot] = 1'b1;
                    tbl_key[free_slot]  = key;
                    tbl_cnt[free_slot]  = COUNT_W'(1);
                    weigh_leader(key, COUNT_W'(1));
                end
            end
        end
        if (px.last_pixel) begin
            res.found          = (lead_cnt != 0);
            res.winner_key     = res.found ? lead_key : '0;
            res.winner_count   = res.found ? lead_cnt : '0;
            res.table_overflow = key_dropped;
            expected_modes.push_back(res);
            frames_done++;
            if (key_dropped) overflow_frames++;
            if (lead_cnt == COUNT_LIMIT) saturated_frames++;
            if (!res.found) empty_frames++;
            clear_tally();
        end
    endfunction

    function pimf_in_t make_pixel(input logic [KEY_W-1:0] key, input bit last);
        pimf_in_t px;
        {px.alpha, px.blue, px.green, px.red} = key;
        px.last_pixel = last;
        return px;
    endfunction

    function void note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Call just after a rising edge; returns just after the edge that takes the transaction.
    task automatic send_pixel(input pimf_in_t px);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        tally_pixel(px);
        pixels_sent++;
    endtask

    // Result side: random backpressure and in-order compare.
    always @(posedge aclk) begin
        pimf_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady_flow || ($urandom_range(0, 99) >= 20);
            if (m_valid && m_ready) begin
                if (expected_modes.size() == 0) begin
                    note_error($sformatf("unexpected result %p", m_data));
                end else begin
                    want = expected_modes.pop_front();
                    if (m_data.found !== want.found
                        || m_data.winner_key !== want.winner_key
                        || m_data.winner_count !== want.winner_count
                        || m_data.table_overflow !== want.table_overflow)
                        note_error({$sformatf("exp found=%0d key=%h count=%0d ovf=%0d, ",
                                              want.found, want.winner_key,
                                              want.winner_count, want.table_overflow),
                                    $sformatf("got found=%0d key=%h count=%0d ovf=%0d",
                                              m_data.found, m_data.winner_key,
                                              m_data.winner_count,
                                              m_data.table_overflow)});
                end
            end
        end
    end

    task automatic test_directed();
        // background only, alpha set: nothing found
        send_pixel(make_pixel(32'hFF00_0000, 1'b1));
        // all-ones key alone
        send_pixel(make_pixel(32'hFFFF_FFFF, 1'b1));
        // three-way tie at count 2, each color byte alone; background last pixel
        send_pixel(make_pixel(32'h0001_0000, 1'b0));
        send_pixel(make_pixel(32'h0000_0100, 1'b0));
        send_pixel(make_pixel(32'h0000_0080, 1'b0));
        send_pixel(make_pixel(32'h0001_0000, 1'b0));
        send_pixel(make_pixel(32'h0000_0100, 1'b0));
        send_pixel(make_pixel(32'h0000_0080, 1'b0));
        send_pixel(make_pixel(32'h5500_0000, 1'b1));
        // alpha alone tells keys apart
        send_pixel(make_pixel(32'h0100_0001, 1'b0));
        send_pixel(make_pixel(32'h0100_0001, 1'b0));
        send_pixel(make_pixel(32'h0000_0001, 1'b1));
        // several background pixels, nothing counted
        send_pixel(make_pixel(32'h0000_0000, 1'b0));
        send_pixel(make_pixel(32'h8000_0000, 1'b0));
        send_pixel(make_pixel(32'h7F00_0000, 1'b1));
        // later key overtakes an earlier leader
        send_pixel(make_pixel(32'h00AA_AAAA, 1'b0));
        send_pixel(make_pixel(32'h0055_5555, 1'b0));
        send_pixel(make_pixel(32'h0055_5555, 1'b1));
    endtask

    task automatic test_table_full();
        // one more distinct key than the table holds, then hits on a kept key
        for (int i = 1; i <= TABLE_ENTRIES + 1; i++)
            send_pixel(make_pixel(32'h0000_0100 * i, 1'b0));
        send_pixel(make_pixel(32'h0000_0300, 1'b0));
        send_pixel(make_pixel(32'h0000_0300, 1'b0));
        send_pixel(make_pixel(32'hDEAD_0001, 1'b1));
        // exactly full, no drop
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_pixel(make_pixel(32'h0010_0000 + i, 1'b0));
        send_pixel(make_pixel(32'h0010_0005, 1'b1));
    endtask

    task automatic test_saturation();
        steady_flow = 1'b1;
        for (int i = 0; i < 130; i++) send_pixel(make_pixel(32'h0020_0000, 1'b0));
        for (int i = 0; i < 130; i++) send_pixel(make_pixel(32'h0010_0000, i == 129));
        steady_flow = 1'b0;
    endtask

    task automatic test_random_frames();
        logic [KEY_W-1:0] palette[20];
        logic [KEY_W-1:0] key;
        int frame_len, pal_size, frame_idx;
        frame_idx = 0;
        while (pixels_sent < 1150 || frame_idx < 45) begin
            steady_flow = (frame_idx >= 8 && frame_idx < 16);
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 100)
                                                     : $urandom_range(1, 40);
            pal_size = $urandom_range(1, 20);
            for (int i = 0; i < pal_size; i++)
                palette[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 8)) : $urandom();
            for (int p = 0; p < frame_len; p++) begin
                if ($urandom_range(0, 99) < 15)
                    key = {8'($urandom()), 24'd0};
                else
                    key = palette[$urandom_range(0, pal_size - 1)];
                send_pixel(make_pixel(key, p == frame_len - 1));
            end
            frame_idx++;
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        clear_tally();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_saturation();
        test_random_frames();
        s_valid <= 1'b0;
        while (expected_modes.size() != 0) @(posedge aclk);
        // catch any stray result
        repeat (40) @(posedge aclk);
        if (expected_modes.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_modes.size()));
        $display("Sent %0d pixels, %0d frames: %0d empty, %0d dropped keys, %0d saturated.",
                 pixels_sent, frames_done, empty_frames, overflow_frames, saturated_frames);
        $display("Mismatches: %0d", err_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_modes.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pimf_pkg.sv
hw/rtl/pimf_table_ram.sv
hw/rtl/pimf_best.sv
hw/rtl/pixel_id_mode_finder.sv
hw/rtl/pimf_checker.sv
sim/tb.sv
